// ===== rtl/core/screen_text_message_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the screen text message parser
// Shared clocking and reset for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef SCREEN_TEXT_MESSAGE_PARSER_MACROS_SVH
`define SCREEN_TEXT_MESSAGE_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define STMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define STMP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/stmp_pkg.sv =====
// ----------------------------------------------------------------------------
// stmp_pkg
// Types, constants and helpers shared by the screen text message parser.
// ----------------------------------------------------------------------------
package stmp_pkg;

  // Text buffer depth; the port widths below are fixed.
  localparam int MAX_TEXT = 32;
  localparam int TEXT_AW  = $clog2(MAX_TEXT);

  localparam int CHAR_W    = 8;
  localparam int NUM_W     = 8;
  localparam int LEN_W     = 6;
  localparam int IDX_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN = 2'd1;

  localparam logic [LEN_W-1:0] MAXLEN_RST = 6'd32;

  // Characters of interest
  localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [CHAR_W-1:0] CH_AT    = 8'h40;  // '@'
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;  // '"'
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_OPCODE,
    ST_SKIP1,
    ST_ID,
    ST_SKIP2,
    ST_ROW,
    ST_SKIP3,
    ST_TEXT,
    ST_EMIT
  } stmp_state_e;

  // Controller to datapath
  typedef struct packed {
    logic id_first;
    logic id_add;
    logic row_first;
    logic row_add;
    logic kept_clear;
    logic store_char;
    logic emit_start;
    logic emit_load;
  } stmp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_lt;
    logic is_at;
    logic is_space;
    logic is_quote;
    logic is_digit;
    logic enable;
    logic kept_room;
    logic out_free;
    logic emit_last;
  } stmp_stat_t;

  // acc * 10 + digit, wrapping at the accumulator width
  function automatic logic [NUM_W-1:0] add_digit(logic [NUM_W-1:0] acc,
                                                 logic [CHAR_W-1:0] c);
    logic [NUM_W-1:0] dval;
    dval = NUM_W'(c - CH_ZERO);
    return (acc << 3) + (acc << 1) + dval;
  endfunction

endpackage

// ===== rtl/core/stmp_dpath.sv =====
// ----------------------------------------------------------------------------
// stmp_dpath
// Datapath: character decode, id/row accumulators, text buffer, config
// registers and the output word register.
// ----------------------------------------------------------------------------
module stmp_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stmp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [stmp_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic [stmp_pkg::CHAR_W-1:0]    in_char_i,
  input  stmp_pkg::stmp_cmd_t            cmd_i,
  output stmp_pkg::stmp_stat_t           stat_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [stmp_pkg::NUM_W-1:0]     screen_id_o,
  output logic [stmp_pkg::NUM_W-1:0]     screen_row_o,
  output logic [stmp_pkg::LEN_W-1:0]     text_length_o,
  output logic [stmp_pkg::IDX_W-1:0]     char_index_o,
  output logic [stmp_pkg::CHAR_W-1:0]    text_char_o,
  output logic                           last_o
);
  import stmp_pkg::*;

  logic                enable_q;
  logic [LEN_W-1:0]    maxlen_q;
  logic [NUM_W-1:0]    id_q, id_d;
  logic [NUM_W-1:0]    row_q, row_d;
  logic [LEN_W-1:0]    kept_q, kept_d;
  logic [LEN_W-1:0]    k_q, k_d;
  logic [CHAR_W-1:0]   text_mem [MAX_TEXT];
  logic [LEN_W-1:0]    limit;
  logic [LEN_W-1:0]    runs;
  logic [NUM_W-1:0]    id_base, row_base;

  logic                out_valid_q;
  logic [NUM_W-1:0]    out_id_q, out_row_q;
  logic [LEN_W-1:0]    out_len_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic [CHAR_W-1:0]   out_char_q;
  logic                out_last_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      maxlen_q <= MAXLEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE: enable_q <= cfg_wdata_i[0];
        CFG_MAXLEN: maxlen_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign limit = (maxlen_q > LEN_W'(MAX_TEXT)) ? LEN_W'(MAX_TEXT) : maxlen_q;
  assign runs  = (kept_q == '0) ? LEN_W'(1) : kept_q;

  always_comb begin
    stat_o.is_lt     = (in_char_i == CH_LT);
    stat_o.is_at     = (in_char_i == CH_AT);
    stat_o.is_space  = (in_char_i == CH_SPACE);
    stat_o.is_quote  = (in_char_i == CH_QUOTE);
    stat_o.is_digit  = (in_char_i >= CH_ZERO) && (in_char_i <= CH_NINE);
    stat_o.enable    = enable_q;
    stat_o.kept_room = (kept_q < limit);
    stat_o.out_free  = !out_valid_q || out_ready_i;
    stat_o.emit_last = ((k_q + LEN_W'(1)) == runs);
  end

  // Accumulators: a first character restarts the number from zero
  always_comb begin
    id_base  = cmd_i.id_first  ? '0 : id_q;
    row_base = cmd_i.row_first ? '0 : row_q;
    id_d     = id_q;
    row_d    = row_q;
    if (cmd_i.id_add)         id_d = add_digit(id_base, in_char_i);
    else if (cmd_i.id_first)  id_d = '0;
    if (cmd_i.row_add)        row_d = add_digit(row_base, in_char_i);
    else if (cmd_i.row_first) row_d = '0;
  end

  always_comb begin
    kept_d = kept_q;
    if (cmd_i.kept_clear)      kept_d = '0;
    else if (cmd_i.store_char) kept_d = kept_q + LEN_W'(1);
    k_d = k_q;
    if (cmd_i.emit_start)     k_d = '0;
    else if (cmd_i.emit_load) k_d = k_q + LEN_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q        <= '0;
      row_q       <= '0;
      kept_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      id_q   <= id_d;
      row_q  <= row_d;
      kept_q <= kept_d;
      k_q    <= k_d;
      if (cmd_i.emit_load)   out_valid_q <= 1'b1;
      else if (out_ready_i)  out_valid_q <= 1'b0;
    end
  end

  // Text buffer; store only below the limit, so the index fits
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_char) begin
      text_mem[kept_q[TEXT_AW-1:0]] <= in_char_i;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_id_q   <= id_q;
      out_row_q  <= row_q;
      out_len_q  <= kept_q;
      out_idx_q  <= IDX_W'(k_q);
      out_char_q <= (kept_q == '0) ? '0 : text_mem[k_q[TEXT_AW-1:0]];
      out_last_q <= stat_o.emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign screen_id_o   = out_id_q;
  assign screen_row_o  = out_row_q;
  assign text_length_o = out_len_q;
  assign char_index_o  = out_idx_q;
  assign text_char_o   = out_char_q;
  assign last_o        = out_last_q;

endmodule

// ===== rtl/core/stmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// stmp_ctrl
// Controller: message phase state machine and emit sequencing.
// ----------------------------------------------------------------------------
module stmp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  stmp_pkg::stmp_stat_t stat_i,
  output stmp_pkg::stmp_cmd_t  cmd_o
);
  import stmp_pkg::*;

  stmp_state_e state_q, state_d;
  logic        acc;

  assign in_ready_o = (state_q != ST_EMIT);
  assign acc        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_HUNT;
    else         state_q <= state_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_HUNT: begin
        if (acc && stat_i.is_lt) state_d = ST_OPCODE;
      end
      ST_OPCODE: begin
        if (acc) state_d = (stat_i.is_at && stat_i.enable) ? ST_SKIP1 : ST_HUNT;
      end
      ST_SKIP1: begin
        if (acc && !stat_i.is_space) state_d = stat_i.is_digit ? ST_ID : ST_HUNT;
      end
      ST_ID: begin
        if (acc) begin
          if (stat_i.is_space)       state_d = ST_SKIP2;
          else if (!stat_i.is_digit) state_d = ST_HUNT;
        end
      end
      ST_SKIP2: begin
        if (acc && !stat_i.is_space) state_d = stat_i.is_digit ? ST_ROW : ST_HUNT;
      end
      ST_ROW: begin
        if (acc) begin
          if (stat_i.is_space)       state_d = ST_SKIP3;
          else if (!stat_i.is_digit) state_d = ST_HUNT;
        end
      end
      ST_SKIP3: begin
        if (acc && !stat_i.is_space) state_d = stat_i.is_quote ? ST_TEXT : ST_HUNT;
      end
      ST_TEXT: begin
        if (acc && stat_i.is_quote) state_d = stat_i.enable ? ST_EMIT : ST_HUNT;
      end
      ST_EMIT: begin
        if (stat_i.out_free && stat_i.emit_last) state_d = ST_HUNT;
      end
      default: state_d = ST_HUNT;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_SKIP1: begin
        // first non-space is the first character of the id
        cmd_o.id_first = acc && !stat_i.is_space;
        cmd_o.id_add   = acc && !stat_i.is_space && stat_i.is_digit;
      end
      ST_ID: begin
        cmd_o.id_add = acc && stat_i.is_digit;
      end
      ST_SKIP2: begin
        cmd_o.row_first = acc && !stat_i.is_space;
        cmd_o.row_add   = acc && !stat_i.is_space && stat_i.is_digit;
      end
      ST_ROW: begin
        cmd_o.row_add = acc && stat_i.is_digit;
      end
      ST_SKIP3: begin
        cmd_o.kept_clear = acc && stat_i.is_quote;
      end
      ST_TEXT: begin
        cmd_o.store_char = acc && !stat_i.is_quote && stat_i.kept_room;
        cmd_o.emit_start = acc && stat_i.is_quote;
      end
      ST_EMIT: begin
        cmd_o.emit_load = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/screen_text_message_parser.sv =====
// ----------------------------------------------------------------------------
// screen_text_message_parser
// Recognizes <@ id row "text"> messages in a character word stream and
// emits the parsed id, row and text one character per output word.
// ----------------------------------------------------------------------------
// Input channel: one character word per handshake (in_valid_i/in_ready_o).
// While parsing, in_ready_o is high and one valid word is taken every cycle.
// Output channel: one result word per handshake (out_valid_o/out_ready_i),
// carrying id, row, kept text length, character index, character and last.
// Results: after the closing quote is taken, the emit state loads a run of
// max(1, text_length) result words through the output register; they leave
// at one word per cycle while the receiver takes each word, and input is
// held off (in_ready_o low) until the last word is loaded. An output stall
// holds the output register and the emit sequencer; the last word may
// still wait while the next message's characters are already taken.
// Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) takes effect at the edge
// of the write; index 0 is parser_enable, index 1 is max_text_length.
// Reset clears the parser to hunting for '<', disables it and sets the text
// limit to 32; the text buffer is not cleared.
// ----------------------------------------------------------------------------
`include "screen_text_message_parser_macros.svh"

module screen_text_message_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stmp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [stmp_pkg::CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [stmp_pkg::CHAR_W-1:0]    in_char_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [stmp_pkg::NUM_W-1:0]     screen_id_o,
  output logic [stmp_pkg::NUM_W-1:0]     screen_row_o,
  output logic [stmp_pkg::LEN_W-1:0]     text_length_o,
  output logic [stmp_pkg::IDX_W-1:0]     char_index_o,
  output logic [stmp_pkg::CHAR_W-1:0]    text_char_o,
  output logic                           last_o
);
  import stmp_pkg::*;

  stmp_cmd_t  cmd;
  stmp_stat_t stat;

  stmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  stmp_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_char_i     (in_char_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .screen_id_o   (screen_id_o),
    .screen_row_o  (screen_row_o),
    .text_length_o (text_length_o),
    .char_index_o  (char_index_o),
    .text_char_o   (text_char_o),
    .last_o        (last_o)
  );

  // Never overwrite an output word that has not been taken
  `STMP_ASSERT_IMP(a_load_free, cmd.emit_load, stat.out_free, "emit load into a busy output")
  // Never store past the text limit
  `STMP_ASSERT_IMP(a_store_room, cmd.store_char, stat.kept_room, "text store beyond limit")
  // After the final word of a run is loaded, input opens again
  `STMP_ASSERT_NXT(a_last_reopen, cmd.emit_load && stat.emit_last, in_ready_o && last_o,
                   "input not reopened after last word")

endmodule
